// ===== hw/rtl/assert_macros.svh =====
// Assertion macros for the checker of the RTL folder (bmp_checker.sv).
// Each macro expects clk_i and rst_ni in the scope where it is used.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define BMP_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define BMP_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== hw/rtl/bmp_pkg.sv =====
// Package of the bit message packer: widths, operation and status codes,
// and the command and status structs between controller and datapath.
// Depends on nothing.
package bmp_pkg;

  localparam int unsigned BUF_BYTES_DEF = 256;
  localparam int unsigned LEN_W         = 9;
  localparam int unsigned LEN_MAX       = (2 ** LEN_W) - 1;
  localparam int unsigned POS_W         = LEN_W + 3;
  localparam int unsigned CNT_W         = 7;
  localparam int unsigned VAL_W         = 32;
  localparam int unsigned FIELD_BYTES   = 5;
  localparam int unsigned SLOT_W        = 3;

  localparam logic [LEN_W-1:0] MAX_BYTES_RST = 9'd256;

  localparam logic [1:0] MODE_WRITE  = 2'd0;
  localparam logic [1:0] MODE_READ   = 2'd1;
  localparam logic [1:0] MODE_BEGIN  = 2'd2;
  localparam logic [1:0] MODE_REWIND = 2'd3;

  localparam logic [1:0] ST_OK      = 2'd0;
  localparam logic [1:0] ST_WR_OVF  = 2'd1;
  localparam logic [1:0] ST_RD_UNF  = 2'd2;
  localparam logic [1:0] ST_BAD_CNT = 2'd3;

  typedef struct packed {
    logic load;
    logic wr_prep;
    logic wr_byte;
    logic rd_prep;
    logic rd_step;
    logic fin;
  } cmd_t;

  typedef struct packed {
    logic [1:0]        mode;
    logic              cnt_ok;
    logic              wr_ovf;
    logic              rd_unf;
    logic [SLOT_W-1:0] nbytes;
  } sts_t;

endpackage

// ===== hw/rtl/bmp_ctrl.sv =====
// Controller of the bit message packer: sequences one item through
// prepare, byte transfer and finish. Depends on bmp_pkg.
module bmp_ctrl (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  output logic          in_ready_o,
  output logic          out_valid_o,
  input  logic          out_ready_i,
  input  bmp_pkg::sts_t sts_i,
  output bmp_pkg::cmd_t cmd_o
);

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_PREP = 3'd1;
  localparam logic [2:0] S_WR   = 3'd2;
  localparam logic [2:0] S_RD   = 3'd3;
  localparam logic [2:0] S_FIN  = 3'd4;

  logic [2:0]                 state_q, state_d;
  logic [bmp_pkg::SLOT_W-1:0] cnt_q, cnt_d;
  logic                       out_valid_q, out_valid_d;
  logic                       out_free;

  assign out_free = !out_valid_q || out_ready_i;

  always_comb begin
    state_d     = state_q;
    cnt_d       = cnt_q;
    cmd_o       = '0;
    out_valid_d = out_valid_q && !out_ready_i;
    unique case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          state_d    = S_PREP;
        end
      end
      S_PREP: begin
        cnt_d = sts_i.nbytes;
        if (sts_i.mode == bmp_pkg::MODE_WRITE && sts_i.cnt_ok && !sts_i.wr_ovf) begin
          cmd_o.wr_prep = 1'b1;
          state_d       = S_WR;
        end else if (sts_i.mode == bmp_pkg::MODE_READ && sts_i.cnt_ok && !sts_i.rd_unf) begin
          cmd_o.rd_prep = 1'b1;
          state_d       = S_RD;
        end else begin
          state_d = S_FIN;
        end
      end
      S_WR: begin
        cmd_o.wr_byte = 1'b1;
        cnt_d         = cnt_q - 3'd1;
        if (cnt_q == 3'd1) begin
          state_d = S_FIN;
        end
      end
      S_RD: begin
        cmd_o.rd_step = 1'b1;
        cnt_d         = cnt_q - 3'd1;
        if (cnt_q == 3'd1) begin
          state_d = S_FIN;
        end
      end
      S_FIN: begin
        if (out_free) begin
          cmd_o.fin   = 1'b1;
          out_valid_d = 1'b1;
          state_d     = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      cnt_q       <= cnt_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign in_ready_o  = (state_q == S_IDLE);
  assign out_valid_o = out_valid_q;

endmodule

// ===== hw/rtl/bmp_dp.sv =====
// Datapath of the bit message packer: byte memory, write and read
// positions, field packing and unpacking, result registers. Depends on bmp_pkg.
module bmp_dp #(
  parameter int unsigned BUF_BYTES = bmp_pkg::BUF_BYTES_DEF
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              cfg_valid_i,
  input  logic [bmp_pkg::LEN_W-1:0]         cfg_max_bytes_i,
  input  logic [1:0]                        mode_i,
  input  logic signed [bmp_pkg::CNT_W-1:0]  bit_count_i,
  input  logic signed [bmp_pkg::VAL_W-1:0]  write_value_i,
  input  bmp_pkg::cmd_t                     cmd_i,
  output bmp_pkg::sts_t                     sts_o,
  output logic signed [bmp_pkg::VAL_W-1:0]  read_value_o,
  output logic [1:0]                        status_o,
  output logic                              value_range_warning_o,
  output logic [bmp_pkg::LEN_W-1:0]         bytes_used_o,
  output logic                              overflow_flag_o
);

  localparam int unsigned AW      = $clog2(BUF_BYTES);
  localparam int unsigned BUF_CAP = (BUF_BYTES > bmp_pkg::LEN_MAX) ? bmp_pkg::LEN_MAX
                                                                   : BUF_BYTES;
  localparam int unsigned LW = bmp_pkg::LEN_W;
  localparam int unsigned PW = bmp_pkg::POS_W;
  localparam int unsigned VW = bmp_pkg::VAL_W;
  localparam int unsigned SW = bmp_pkg::SLOT_W;

  // Architectural state.
  logic [LW-1:0] max_bytes_q;
  logic [LW-1:0] wl_q, rl_q;
  logic [2:0]    wbp_q, rbp_q;
  logic          ovf_q;

  // Item and working registers.
  logic [1:0]                      mode_q;
  logic signed [bmp_pkg::CNT_W-1:0] cnt_q;
  logic signed [VW-1:0]            wv_q;
  logic [7:0]                      part_q;
  logic [8*bmp_pkg::FIELD_BYTES-1:0] sh_q;
  logic [AW-1:0]                   waddr_q, raddr_q;
  logic [7:0]                      rdata_q;
  logic [7:0]                      acc_q [bmp_pkg::FIELD_BYTES];
  logic [SW-1:0]                   slot_q;
  logic [7:0]                      mem_q [BUF_BYTES];

  // Result registers.
  logic signed [VW-1:0] rv_q;
  logic [1:0]           st_q;
  logic                 warn_q;

  logic                          neg;
  logic [bmp_pkg::CNT_W-1:0]     neg_cnt;
  logic [5:0]                    bits;
  logic [4:0]                    top_bit;
  logic                          cnt_ok;
  logic [PW-1:0]                 bw, br, lim_bits;
  logic [LW-1:0]                 lim9;
  logic [PW:0]                   wr_end, rd_end, wr_last, rd_last;
  logic                          wr_ovf, rd_unf;
  logic [SW-1:0]                 nb_w, nb_r;
  logic [LW-1:0]                 wl_new, rl_new;
  logic [VW-1:0]                 mask, wv_m, ext, rd_val;
  logic signed [VW-1:0]          sgn_top;
  logic                          warn;
  logic [8*bmp_pkg::FIELD_BYTES-1:0] sh_init, acc_vec;
  logic [AW-1:0]                 f_w, f_r;
  logic signed [VW-1:0]          rv_n;
  logic [1:0]                    st_n;
  logic                          warn_n;

  always_comb begin
    neg     = cnt_q[bmp_pkg::CNT_W-1];
    neg_cnt = -cnt_q;
    bits    = neg ? neg_cnt[5:0] : cnt_q[5:0];
    top_bit = 5'(bits - 6'd1);
    cnt_ok  = (cnt_q != '0) && (cnt_q >= -7'sd31) && (cnt_q <= 7'sd32);

    // Bit positions: bytes opened times eight, less the unused top of the last byte.
    bw = (wbp_q == 3'd0) ? {wl_q, 3'b000} : {wl_q - 9'd1, wbp_q};
    br = (rbp_q == 3'd0) ? {rl_q, 3'b000} : {rl_q - 9'd1, rbp_q};

    lim9     = (max_bytes_q > LW'(BUF_CAP)) ? LW'(BUF_CAP) : max_bytes_q;
    lim_bits = {lim9, 3'b000};

    wr_end = {1'b0, bw} + (PW + 1)'(bits);
    rd_end = {1'b0, br} + (PW + 1)'(bits);
    wr_ovf = wr_end > {1'b0, lim_bits};
    rd_unf = rd_end > {1'b0, bw};

    wr_last = wr_end - 13'd1;
    rd_last = rd_end - 13'd1;
    nb_w    = SW'(wr_last[PW:3] - {1'b0, bw[PW-1:3]} + 10'd1);
    nb_r    = SW'(rd_last[PW:3] - {1'b0, br[PW-1:3]} + 10'd1);
    wl_new  = LW'((wr_end + 13'd7) >> 3);
    rl_new  = LW'((rd_end + 13'd7) >> 3);

    // A shift by the full width yields zero, so a 32-bit field masks nothing.
    mask = ~({VW{1'b1}} << bits);
    wv_m = wv_q & mask;

    sgn_top = wv_q >>> top_bit;
    warn    = neg ? !((sgn_top == '0) || (sgn_top == '1)) : |(wv_q & ~mask);

    sh_init = ({8'h00, wv_m} << wbp_q)
            | {32'h0, ((wbp_q != 3'd0) ? part_q : 8'h00)};

    acc_vec = {acc_q[4], acc_q[3], acc_q[2], acc_q[1], acc_q[0]};
    ext     = VW'(acc_vec >> br[2:0]) & mask;
    rd_val  = (neg && ext[top_bit]) ? (ext | ~mask) : ext;

    f_w = AW'(bw[PW-1:3]);
    f_r = AW'(br[PW-1:3]);
  end

  always_comb begin
    rv_n   = '0;
    st_n   = bmp_pkg::ST_OK;
    warn_n = 1'b0;
    case (mode_q)
      bmp_pkg::MODE_WRITE: begin
        if (!cnt_ok) begin
          st_n = bmp_pkg::ST_BAD_CNT;
        end else begin
          warn_n = warn;
          if (wr_ovf) begin
            st_n = bmp_pkg::ST_WR_OVF;
          end
        end
      end
      bmp_pkg::MODE_READ: begin
        if (!cnt_ok) begin
          st_n = bmp_pkg::ST_BAD_CNT;
        end else if (rd_unf) begin
          rv_n = '1;
          st_n = bmp_pkg::ST_RD_UNF;
        end else begin
          rv_n = rd_val;
        end
      end
      default: begin
        rv_n = '0;
      end
    endcase
  end

  // Byte memory: one write and one registered read per cycle.
  always_ff @(posedge clk_i) begin
    if (cmd_i.wr_byte) begin
      mem_q[waddr_q] <= sh_q[7:0];
    end
    if (cmd_i.rd_prep || cmd_i.rd_step) begin
      rdata_q <= mem_q[cmd_i.rd_prep ? f_r : raddr_q];
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      mode_q <= mode_i;
      cnt_q  <= bit_count_i;
      wv_q   <= write_value_i;
    end
    if (cmd_i.wr_prep) begin
      sh_q    <= sh_init;
      waddr_q <= f_w;
    end
    if (cmd_i.wr_byte) begin
      sh_q    <= sh_q >> 8;
      waddr_q <= waddr_q + AW'(1);
      part_q  <= sh_q[7:0];
    end
    if (cmd_i.rd_prep) begin
      raddr_q <= f_r + AW'(1);
      slot_q  <= '0;
    end
    if (cmd_i.rd_step) begin
      for (int i = 0; i < bmp_pkg::FIELD_BYTES; i++) begin
        if (slot_q == SW'(i)) begin
          acc_q[i] <= rdata_q;
        end
      end
      slot_q  <= slot_q + 3'd1;
      raddr_q <= raddr_q + AW'(1);
    end
    if (cmd_i.fin) begin
      rv_q   <= rv_n;
      st_q   <= st_n;
      warn_q <= warn_n;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      max_bytes_q <= bmp_pkg::MAX_BYTES_RST;
      wl_q        <= '0;
      wbp_q       <= '0;
      rl_q        <= '0;
      rbp_q       <= '0;
      ovf_q       <= 1'b0;
    end else begin
      if (cfg_valid_i) begin
        max_bytes_q <= cfg_max_bytes_i;
      end
      if (cmd_i.fin) begin
        unique case (mode_q)
          bmp_pkg::MODE_WRITE: begin
            if (cnt_ok) begin
              if (wr_ovf) begin
                wl_q  <= '0;
                wbp_q <= '0;
                ovf_q <= 1'b1;
              end else begin
                wl_q  <= wl_new;
                wbp_q <= wr_end[2:0];
              end
            end
          end
          bmp_pkg::MODE_READ: begin
            if (cnt_ok && !rd_unf) begin
              rl_q  <= rl_new;
              rbp_q <= rd_end[2:0];
            end
          end
          bmp_pkg::MODE_BEGIN: begin
            wl_q  <= '0;
            wbp_q <= '0;
            ovf_q <= 1'b0;
          end
          bmp_pkg::MODE_REWIND: begin
            rl_q  <= '0;
            rbp_q <= '0;
          end
          default: begin
            rl_q <= rl_q;
          end
        endcase
      end
    end
  end

  assign sts_o.mode   = mode_q;
  assign sts_o.cnt_ok = cnt_ok;
  assign sts_o.wr_ovf = wr_ovf;
  assign sts_o.rd_unf = rd_unf;
  assign sts_o.nbytes = (mode_q == bmp_pkg::MODE_READ) ? nb_r : nb_w;

  assign read_value_o          = rv_q;
  assign status_o              = st_q;
  assign value_range_warning_o = warn_q;
  // Write length and overflow only change when a result is loaded.
  assign bytes_used_o          = wl_q;
  assign overflow_flag_o       = ovf_q;

endmodule

// ===== hw/rtl/bit_message_packer_core.sv =====
// Top level of the bit message packer: controller plus datapath.
// Depends on bmp_pkg, bmp_ctrl and bmp_dp.
//
// A byte message packed and unpacked least-significant bit first, in fields
// of 1 to 32 bits (a negative bit count reads a signed, sign-extended field).
// Every input item yields exactly one result item. A write or read whose
// field touches k bytes (k = 1..5) goes through these steps: take the item,
// check it and address the first byte, transfer the k bytes, load the
// result. Begin-writing, rewind-reading, rejected counts, overflows and
// underflows go from the check straight to loading the result. The byte
// transfers are paced by the byte memory, which moves one byte per cycle.
// The result sits in its own register, so the next item is taken while
// the previous result still waits; only loading a new result waits on that
// register. The size register is written over its own channel and is always
// ready; write it only while no item is in flight. Message bytes have no
// reset and need no clearing pass, since reads only reach written bytes.
module bit_message_packer_core #(
  parameter int unsigned BUF_BYTES = bmp_pkg::BUF_BYTES_DEF
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              in_valid_i,
  output logic                              in_ready_o,
  input  logic [1:0]                        mode_i,
  input  logic signed [bmp_pkg::CNT_W-1:0]  bit_count_i,
  input  logic signed [bmp_pkg::VAL_W-1:0]  write_value_i,
  output logic                              out_valid_o,
  input  logic                              out_ready_i,
  output logic signed [bmp_pkg::VAL_W-1:0]  read_value_o,
  output logic [1:0]                        status_o,
  output logic                              value_range_warning_o,
  output logic [bmp_pkg::LEN_W-1:0]         bytes_used_o,
  output logic                              overflow_flag_o,
  input  logic                              cfg_valid_i,
  output logic                              cfg_ready_o,
  input  logic [bmp_pkg::LEN_W-1:0]         cfg_max_bytes_i
);

  bmp_pkg::cmd_t cmd;
  bmp_pkg::sts_t sts;

  // The size register accepts a transfer in any cycle.
  assign cfg_ready_o = 1'b1;

  bmp_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .sts_i       (sts),
    .cmd_o       (cmd)
  );

  bmp_dp #(
    .BUF_BYTES (BUF_BYTES)
  ) u_dp (
    .clk_i                 (clk_i),
    .rst_ni                (rst_ni),
    .cfg_valid_i           (cfg_valid_i),
    .cfg_max_bytes_i       (cfg_max_bytes_i),
    .mode_i                (mode_i),
    .bit_count_i           (bit_count_i),
    .write_value_i         (write_value_i),
    .cmd_i                 (cmd),
    .sts_o                 (sts),
    .read_value_o          (read_value_o),
    .status_o              (status_o),
    .value_range_warning_o (value_range_warning_o),
    .bytes_used_o          (bytes_used_o),
    .overflow_flag_o       (overflow_flag_o)
  );

endmodule

// ===== hw/rtl/bmp_checker.sv =====
// Port-level checker of the bit message packer and its bind to the top level.
// Depends on bmp_pkg and assert_macros.svh.
`include "assert_macros.svh"

module bmp_checker (
  input logic                              clk_i,
  input logic                              rst_ni,
  input logic                              in_valid_i,
  input logic                              in_ready_o,
  input logic                              out_valid_o,
  input logic                              out_ready_i,
  input logic signed [bmp_pkg::VAL_W-1:0]  read_value_o,
  input logic [1:0]                        status_o,
  input logic                              value_range_warning_o,
  input logic [bmp_pkg::LEN_W-1:0]         bytes_used_o,
  input logic                              overflow_flag_o
);

  // A stalled result holds until its transfer.
  `BMP_ASSERT_NXT(a_out_hold, out_valid_o && !out_ready_i, out_valid_o && $stable(read_value_o) && $stable(status_o), "result changed while stalled")

  // The block is busy on the cycle after it takes an item.
  `BMP_ASSERT_NXT(a_busy_after_take, in_valid_i && in_ready_o, !in_ready_o, "item taken back to back")

  // A read past the written bits answers all ones.
  `BMP_ASSERT_IMP(a_unf_value, out_valid_o && status_o == bmp_pkg::ST_RD_UNF, read_value_o == 32'hFFFF_FFFF, "underflow value is not all ones")

  // An overflowing write empties the message and raises the sticky flag.
  `BMP_ASSERT_IMP(a_ovf_empties, out_valid_o && status_o == bmp_pkg::ST_WR_OVF, overflow_flag_o && bytes_used_o == '0, "overflow did not empty the message")

  // A rejected count gives a zero value and no warning.
  `BMP_ASSERT_IMP(a_bad_cnt_quiet, out_valid_o && status_o == bmp_pkg::ST_BAD_CNT, read_value_o == '0 && !value_range_warning_o, "rejected count gave a value or warning")

endmodule

bind bit_message_packer_core bmp_checker u_bmp_checker (.*);
